// ===== hw/rtl/lsoa_pkg.sv =====
`timescale 1ns / 1ps

package lsoa_pkg;

  // Scan geometry.
  localparam int MAX_SCAN_SAMPLES = 4096;
  localparam int IDX_W = $clog2(MAX_SCAN_SAMPLES);
  localparam int LEN_W = IDX_W + 1;
  localparam int MIN_SCAN_SAMPLES = 3;

  // Reciprocal of three for lengths up to MAX_SCAN_SAMPLES: n/3 == (n*RECIP3) >> RECIP3_SHIFT.
  localparam int RECIP3_SHIFT = LEN_W;
  localparam int RECIP3 = ((1 << RECIP3_SHIFT) + 2) / 3;
  localparam int RECIP3_W = RECIP3_SHIFT;

  // Field widths.
  localparam int RANGE_W = 16;
  localparam int SPEED_W = 12;
  localparam int ANG_W = 13;
  localparam int DUR_W = 10;
  localparam int CNT_W = 11;
  localparam int LFSR_W = 32;
  localparam int BIT_W = $clog2(LFSR_W);

  // Stream payload widths.
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID_DUR = 3'd6;

  // Register reset values.
  localparam logic [LEN_W-1:0] RST_SCAN_LENGTH = 13'd720;
  localparam logic [RANGE_W-1:0] RST_FRONT_DIST = 16'd1200;
  localparam logic [RANGE_W-1:0] RST_STOP_DIST = 16'd600;
  localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 12'd750;
  localparam logic [SPEED_W-1:0] RST_AVOID_SPEED = 12'd300;
  localparam logic [SPEED_W-1:0] RST_TURN_RATE = 12'd800;
  localparam logic [DUR_W-1:0] RST_AVOID_DUR = 10'd50;

  // Random source.
  localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;
  localparam logic [RANGE_W-1:0] RANGE_MAX = 16'hFFFF;

  // Packed result item, highest field first.
  typedef struct packed {
    logic [OUT_TDATA_W-SPEED_W-ANG_W-3:0] pad;
    logic stopped;
    logic avoiding;
    logic [ANG_W-1:0] angular_rate;
    logic [SPEED_W-1:0] linear_speed;
  } out_item_t;

  // One step of the Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_MASK;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/laser_scan_obstacle_avoider.sv =====
`timescale 1ns / 1ps

// Reactive obstacle avoider fed one laser range sample (mm) per input transaction; after the
// last sample of each scan it sends one drive command transaction. All range compares and the
// remainder for the random hold length run through one shared 17-bit subtractor under a small
// sequencer, so each sample steps in turn through accept, sector placement, then front, stop
// and half-minimum compares before the next is taken. The last sample of a scan adds decision
// and command output steps, plus a remainder pass when a new avoidance starts (one remainder
// bit per cycle over the 32-bit LFSR, then the counter load), and it waits further if the
// previous command has not yet been taken. Configuration registers sit at byte addresses 4*i
// in the order scan_length, front_distance_mm, stop_distance_mm, cruise_speed, avoid_speed,
// turn_rate, avoid_duration; write them only while in_tready is high, between sample
// transactions. A new scan length applies from the next sample.
module laser_scan_obstacle_avoider (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Range samples.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lsoa_pkg::IN_TDATA_W-1:0]      in_tdata,    // [15:0] range_mm
  // Drive commands.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [11:0] linear_speed, [24:12] angular_rate, [25] avoiding, [26] stopped, [31:27] zero
  output logic [lsoa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lsoa_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [lsoa_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [lsoa_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int IW = lsoa_pkg::IDX_W;
  localparam int LW = lsoa_pkg::LEN_W;
  localparam int RW = lsoa_pkg::RANGE_W;
  localparam int SW = lsoa_pkg::SPEED_W;
  localparam int AW = lsoa_pkg::ANG_W;
  localparam int DW = lsoa_pkg::DUR_W;
  localparam int CW = lsoa_pkg::CNT_W;
  localparam int FW = lsoa_pkg::LFSR_W;
  localparam int BW = lsoa_pkg::BIT_W;
  localparam int PW = LW + lsoa_pkg::RECIP3_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PLACE  = 4'd1;
  localparam logic [3:0] S_FRONT  = 4'd2;
  localparam logic [3:0] S_STOP   = 4'd3;
  localparam logic [3:0] S_MINUPD = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  // Configuration registers.
  logic [LW-1:0] scan_len_r;
  logic [RW-1:0] front_dist_r;
  logic [RW-1:0] stop_dist_r;
  logic [SW-1:0] cruise_r;
  logic [SW-1:0] avoid_spd_r;
  logic [SW-1:0] turn_r;
  logic [DW-1:0] dur_r;

  // Scan and avoidance state.
  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] lmin_r, lmin_nxt;
  logic [RW-1:0] rmin_r, rmin_nxt;
  logic          obst_r, obst_nxt;
  logic          stop_r, stop_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          held_left_r, held_left_nxt;
  logic [FW-1:0] lfsr_r, lfsr_nxt;

  // Per-sample and remainder working registers.
  logic [RW-1:0] sample_r, sample_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] third_r, third_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [BW-1:0] bit_r, bit_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  lsoa_pkg::out_item_t   out_item_r, out_item_nxt;

  // Shared subtractor.
  logic [RW-1:0] alu_a, alu_b;
  logic [RW:0]   alu_diff;
  logic          alu_lt;

  logic [LW-1:0] eff_len;
  logic [PW-1:0] third_prod;
  logic [LW-1:0] idx_ext;
  logic [DW-1:0] dur_eff;
  logic [DW:0]   rem_sh;
  logic          in_front, left_half, avoid, out_free;
  logic [AW-1:0] turn_ext;
  logic          cfg_wr;
  logic [lsoa_pkg::CFG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[lsoa_pkg::CFG_ADDR_W-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_len_r   <= lsoa_pkg::RST_SCAN_LENGTH;
      front_dist_r <= lsoa_pkg::RST_FRONT_DIST;
      stop_dist_r  <= lsoa_pkg::RST_STOP_DIST;
      cruise_r     <= lsoa_pkg::RST_CRUISE_SPEED;
      avoid_spd_r  <= lsoa_pkg::RST_AVOID_SPEED;
      turn_r       <= lsoa_pkg::RST_TURN_RATE;
      dur_r        <= lsoa_pkg::RST_AVOID_DUR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lsoa_pkg::REG_SCAN_LENGTH:  scan_len_r   <= cfg_pwdata[LW-1:0];
        lsoa_pkg::REG_FRONT_DIST:   front_dist_r <= cfg_pwdata[RW-1:0];
        lsoa_pkg::REG_STOP_DIST:    stop_dist_r  <= cfg_pwdata[RW-1:0];
        lsoa_pkg::REG_CRUISE_SPEED: cruise_r     <= cfg_pwdata[SW-1:0];
        lsoa_pkg::REG_AVOID_SPEED:  avoid_spd_r  <= cfg_pwdata[SW-1:0];
        lsoa_pkg::REG_TURN_RATE:    turn_r       <= cfg_pwdata[SW-1:0];
        lsoa_pkg::REG_AVOID_DUR:    dur_r        <= cfg_pwdata[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      lsoa_pkg::REG_SCAN_LENGTH:  cfg_prdata = 32'(scan_len_r);
      lsoa_pkg::REG_FRONT_DIST:   cfg_prdata = 32'(front_dist_r);
      lsoa_pkg::REG_STOP_DIST:    cfg_prdata = 32'(stop_dist_r);
      lsoa_pkg::REG_CRUISE_SPEED: cfg_prdata = 32'(cruise_r);
      lsoa_pkg::REG_AVOID_SPEED:  cfg_prdata = 32'(avoid_spd_r);
      lsoa_pkg::REG_TURN_RATE:    cfg_prdata = 32'(turn_r);
      lsoa_pkg::REG_AVOID_DUR:    cfg_prdata = 32'(dur_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Effective scan length and avoid duration.
  always_comb begin
    if (scan_len_r < LW'(lsoa_pkg::MIN_SCAN_SAMPLES)) begin
      eff_len = LW'(lsoa_pkg::MIN_SCAN_SAMPLES);
    end else if (scan_len_r > LW'(lsoa_pkg::MAX_SCAN_SAMPLES)) begin
      eff_len = LW'(lsoa_pkg::MAX_SCAN_SAMPLES);
    end else begin
      eff_len = scan_len_r;
    end
  end
  assign dur_eff = (dur_r == '0) ? DW'(1) : dur_r;

  // Sector placement of the current sample.
  assign third_prod = PW'(eff_len) * PW'(lsoa_pkg::RECIP3);
  assign idx_ext = LW'(idx_r);
  assign in_front = (idx_ext > third_r) && (idx_ext < (eff_len - third_r));
  assign left_half = idx_ext > (eff_len >> 1);

  assign rem_sh = {rem_r, lfsr_r[bit_r]};

  // Shared subtractor operand selection.
  always_comb begin
    alu_a = sample_r;
    alu_b = front_dist_r;
    unique case (state_r)
      S_STOP:   alu_b = stop_dist_r;
      S_MINUPD: alu_b = left_half ? lmin_r : rmin_r;
      S_DIV: begin
        alu_a = RW'(rem_sh);
        alu_b = RW'(dur_eff);
      end
      S_LOAD: begin
        alu_a = lmin_r;
        alu_b = rmin_r;
      end
      default: begin
      end
    endcase
  end
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt = alu_diff[RW];

  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign avoid = obst_r || stop_r || (cnt_r != '0);
  assign turn_ext = AW'(turn_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_item_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    lmin_nxt      = lmin_r;
    rmin_nxt      = rmin_r;
    obst_nxt      = obst_r;
    stop_nxt      = stop_r;
    cnt_nxt       = cnt_r;
    held_left_nxt = held_left_r;
    lfsr_nxt      = lfsr_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    third_nxt     = third_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[RW-1:0];
          last_nxt = !((idx_ext + LW'(1)) < eff_len);
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        third_nxt = third_prod[PW-1:lsoa_pkg::RECIP3_SHIFT];
        state_nxt = S_FRONT;
      end
      S_FRONT: begin
        if (in_front && alu_lt) begin
          obst_nxt = 1'b1;
        end
        state_nxt = S_STOP;
      end
      S_STOP: begin
        if (alu_lt) begin
          stop_nxt = 1'b1;
        end
        state_nxt = S_MINUPD;
      end
      S_MINUPD: begin
        if (alu_lt) begin
          if (left_half) begin
            lmin_nxt = sample_r;
          end else begin
            rmin_nxt = sample_r;
          end
        end
        if (last_r) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_DECIDE: begin
        // A new avoidance draws a fresh random hold length.
        if (avoid && (cnt_r == '0)) begin
          lfsr_nxt = lsoa_pkg::lfsr_next(lfsr_r);
          rem_nxt = '0;
          bit_nxt = BW'(FW - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        // Restoring remainder, one LFSR bit per cycle from the top.
        rem_nxt = alu_lt ? rem_sh[DW-1:0] : alu_diff[DW-1:0];
        if (bit_r == '0) begin
          state_nxt = S_LOAD;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      S_LOAD: begin
        cnt_nxt = CW'(rem_r) + CW'(dur_eff);
        held_left_nxt = !alu_lt;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.pad = '0;
          out_item_nxt.avoiding = avoid;
          out_item_nxt.stopped = stop_r;
          if (avoid) begin
            out_item_nxt.linear_speed = stop_r ? '0 : avoid_spd_r;
            out_item_nxt.angular_rate = held_left_r ? turn_ext : (AW'(0) - turn_ext);
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            out_item_nxt.linear_speed = cruise_r;
            out_item_nxt.angular_rate = '0;
            cnt_nxt = '0;
          end
          // Start the next scan.
          idx_nxt = '0;
          lmin_nxt = lsoa_pkg::RANGE_MAX;
          rmin_nxt = lsoa_pkg::RANGE_MAX;
          obst_nxt = 1'b0;
          stop_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      lmin_r      <= lsoa_pkg::RANGE_MAX;
      rmin_r      <= lsoa_pkg::RANGE_MAX;
      obst_r      <= 1'b0;
      stop_r      <= 1'b0;
      cnt_r       <= '0;
      held_left_r <= 1'b0;
      lfsr_r      <= lsoa_pkg::LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      lmin_r      <= lmin_nxt;
      rmin_r      <= rmin_nxt;
      obst_r      <= obst_nxt;
      stop_r      <= stop_nxt;
      cnt_r       <= cnt_nxt;
      held_left_r <= held_left_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    third_r    <= third_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hw/rtl/lsoa_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the drive command stream.
module lsoa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lsoa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lsoa_pkg::out_item_t item;
  assign item = out_tdata;

  // A stalled command holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("command changed while stalled");

  // A cruise command goes straight and never reports a stop.
  a_cruise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !item.avoiding |-> (item.angular_rate == '0) && !item.stopped)
    else $error("cruise command with turn or stop");

  // A stop is always an avoidance with zero speed.
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && item.stopped |-> item.avoiding && (item.linear_speed == '0))
    else $error("stop command with speed or without avoidance");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("command pending after reset");

endmodule

bind laser_scan_obstacle_avoider lsoa_checker u_lsoa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
